FILE: rtl/mevm_pkg.sv
// ============================================================================
// Motor energy and vibration meter: shared package
// Sizes, register indexes, controller states and the command and status
// structures that pass between the controller and the datapath.
// ============================================================================
package mevm_pkg;

    // Motor and group counts, and the index widths that follow from them.
    localparam int MOTORS      = 16;
    localparam int GROUPS      = 4;
    localparam int MOTOR_IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int GROUP_IDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    // Field widths.
    localparam int DATA_W  = 32;
    localparam int MOTOR_W = 4;
    localparam int GROUP_W = 2;
    localparam int TOTAL_W = 63;
    localparam int PROD_W  = 65;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMESTEP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TIMESTEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_MAP    = 2'd2;

    // Configuration reset values.
    localparam logic [DATA_W-1:0] TIMESTEP_RST     = 32'd8589935;
    localparam logic [DATA_W-1:0] INV_TIMESTEP_RST = 32'd32768000;
    localparam logic [DATA_W-1:0] GROUP_MAP_RST    = 32'd0;

    // Input operation codes.
    localparam logic OP_METER = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACCEL,
        ST_POWER,
        ST_ELO,
        ST_EHI,
        ST_SUM,
        ST_UPDATE,
        ST_CLEAR,
        ST_RESULT
    } t_state;

    // Operand selection of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_ACCEL,
        MUL_POWER,
        MUL_ELO,
        MUL_EHI
    } t_mul_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sum;
        logic     update;
        logic     clear;
        logic     out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_op;
        logic in_live;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/mevm_ctrl.sv
// ============================================================================
// Motor energy and vibration meter: controller
// Sequences one word through the shared multiplier, the accumulation and
// the output register, and skips the arithmetic for clear and dead words.
// ============================================================================
module mevm_ctrl
    import mevm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.mul_sel  = MUL_ACCEL;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_op == OP_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else if (i_sts.in_live) begin
                        n_state = ST_ACCEL;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_ACCEL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_ACCEL;
                n_state       = ST_POWER;
            end
            ST_POWER: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_POWER;
                n_state       = ST_ELO;
            end
            ST_ELO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_ELO;
                n_state       = ST_EHI;
            end
            ST_EHI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_EHI;
                n_state       = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_RESULT;
            end
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A word is taken only in the idle state, so the next cycle is busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("controller accepted a word without leaving idle");

    // A finished result waits until the output register is free.
    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && !i_sts.out_free) |=> (r_state == ST_RESULT))
        else $error("result dropped while the output register was full");

endmodule

FILE: rtl/mevm_dp.sv
// ============================================================================
// Motor energy and vibration meter: datapath
// Configuration registers, per-motor history, per-group totals, one shared
// 33x32 multiplier and the output register.
// ============================================================================
module mevm_dp
    import mevm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration writes.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_wdata,
    // Input word fields.
    input  logic                 i_op,
    input  logic [MOTOR_W-1:0]   i_motor,
    input  logic                 i_alive,
    input  logic signed [DATA_W-1:0] i_joint_velocity,
    input  logic signed [DATA_W-1:0] i_torque,
    // Output side.
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [GROUP_W-1:0]   o_group,
    output logic                 o_updated,
    output logic [TOTAL_W-1:0]   o_group_energy,
    output logic [TOTAL_W-1:0]   o_group_vibration,
    // Controller link.
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts
);

    // Configuration registers.
    logic [DATA_W-1:0] r_timestep;
    logic [DATA_W-1:0] r_inv_timestep;
    logic [DATA_W-1:0] r_group_map;

    // Per-motor history; an entry that is not valid reads as zero.
    logic [DATA_W-1:0] r_hist_vel [MOTORS];
    logic [DATA_W-1:0] r_hist_acc [MOTORS];
    logic [MOTORS-1:0] r_hvalid;

    // Per-group totals.
    logic [TOTAL_W-1:0] r_energy [GROUPS];
    logic [TOTAL_W-1:0] r_vibr   [GROUPS];

    // Latched word.
    logic                r_op;
    logic                r_live;
    logic [MOTOR_W-1:0]  r_motor;
    logic [DATA_W-1:0]   r_vel;
    logic [DATA_W:0]     r_absd;
    logic                r_dneg;
    logic [DATA_W-1:0]   r_abs_tau;
    logic [DATA_W-1:0]   r_abs_vel;

    // Arithmetic intermediates.
    logic [PROD_W-1:0]   r_prod;
    logic [DATA_W-1:0]   r_acc;
    logic [30:0]         r_phi;
    logic [DATA_W-1:0]   r_elo;
    logic [TOTAL_W-1:0]  r_e;
    logic [DATA_W:0]     r_vib;

    // Output register.
    logic                r_out_valid;
    logic [GROUP_W-1:0]  r_out_group;
    logic                r_out_upd;
    logic [TOTAL_W-1:0]  r_out_energy;
    logic [TOTAL_W-1:0]  r_out_vibr;

    logic                   in_live;
    logic [MOTOR_IDX_W-1:0] in_midx;
    logic [DATA_W-1:0]      in_pv;
    logic signed [DATA_W:0] in_d;
    logic [MOTOR_IDX_W-1:0] midx;
    logic [DATA_W-1:0]      pa;
    logic [GROUP_W-1:0]     grp_raw;
    logic [GROUP_W-1:0]     grp;
    logic [GROUP_IDX_W-1:0] gidx;
    logic [DATA_W:0]        mul_a;
    logic [DATA_W-1:0]      mul_b;
    logic [PROD_W-1:0]      mul_p;
    logic [48:0]            q;
    logic [DATA_W-1:0]      acc_sat;
    logic signed [DATA_W:0] vdiff;
    logic [TOTAL_W:0]       sum_e;
    logic [TOTAL_W:0]       sum_v;

    // Input decode and the velocity difference, taken at accept time.
    always_comb begin
        in_live = i_alive && ({1'b0, i_motor} < (MOTOR_W + 1)'(MOTORS));
        in_midx = i_motor[MOTOR_IDX_W-1:0];
        in_pv   = r_hvalid[in_midx] ? r_hist_vel[in_midx] : '0;
        in_d    = {i_joint_velocity[DATA_W-1], i_joint_velocity}
                - {in_pv[DATA_W-1], in_pv};
    end

    assign o_sts.in_op    = i_op;
    assign o_sts.in_live  = in_live;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // Group of the latched motor, saturated to the last group.
    always_comb begin
        midx    = r_motor[MOTOR_IDX_W-1:0];
        pa      = r_hvalid[midx] ? r_hist_acc[midx] : '0;
        grp_raw = r_group_map[{r_motor, 1'b0} +: GROUP_W];
        if ({1'b0, grp_raw} >= (GROUP_W + 1)'(GROUPS)) begin
            grp = GROUP_W'(GROUPS - 1);
        end else begin
            grp = grp_raw;
        end
        gidx = grp[GROUP_IDX_W-1:0];
    end

    // Shared multiplier operand selection.
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_ACCEL: begin
                mul_a = r_absd;
                mul_b = r_inv_timestep;
            end
            MUL_POWER: begin
                mul_a = {1'b0, r_abs_tau};
                mul_b = r_abs_vel;
            end
            MUL_ELO: begin
                mul_a = {1'b0, r_prod[DATA_W-1:0]};
                mul_b = r_timestep;
            end
            MUL_EHI: begin
                mul_a = {2'b00, r_phi};
                mul_b = r_timestep;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Acceleration: the scaled difference, truncated, sign restored, saturated.
    always_comb begin
        q = r_prod[64:16];
        if (r_dneg) begin
            acc_sat = (q > 49'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - q[DATA_W-1:0]);
        end else begin
            acc_sat = (q > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[DATA_W-1:0];
        end
        vdiff = {r_acc[DATA_W-1], r_acc} - {pa[DATA_W-1], pa};
    end

    // Saturating accumulation into the selected group.
    always_comb begin
        sum_e = {1'b0, r_energy[gidx]} + {1'b0, r_e};
        sum_v = {1'b0, r_vibr[gidx]} + (TOTAL_W + 1)'(r_vib);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timestep     <= TIMESTEP_RST;
            r_inv_timestep <= INV_TIMESTEP_RST;
            r_group_map    <= GROUP_MAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TIMESTEP:     r_timestep     <= i_cfg_wdata;
                REG_INV_TIMESTEP: r_inv_timestep <= i_cfg_wdata;
                REG_GROUP_MAP:    r_group_map    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Word latch and arithmetic pipeline registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_live    <= in_live;
            r_motor   <= i_motor;
            r_vel     <= i_joint_velocity;
            r_dneg    <= in_d[DATA_W];
            r_absd    <= in_d[DATA_W] ? ((DATA_W + 1)'(0) - in_d) : in_d;
            r_abs_tau <= i_torque[DATA_W-1] ? (32'd0 - i_torque) : i_torque;
            r_abs_vel <= i_joint_velocity[DATA_W-1] ? (32'd0 - i_joint_velocity)
                                                    : i_joint_velocity;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
            case (i_cmd.mul_sel)
                MUL_POWER: r_acc <= acc_sat;
                MUL_ELO:   r_phi <= r_prod[62:32];
                MUL_EHI:   r_elo <= r_prod[63:32];
                default: begin
                end
            endcase
        end
        if (i_cmd.sum) begin
            r_e   <= r_prod[TOTAL_W-1:0] + TOTAL_W'(r_elo);
            r_vib <= vdiff[DATA_W] ? ((DATA_W + 1)'(0) - vdiff) : vdiff;
        end
    end

    // History payload; the valid bits below tell which entries hold data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_hist_vel[midx] <= r_vel;
            r_hist_acc[midx] <= r_acc;
        end
    end

    // History valid bits and group totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_hvalid <= '0;
            for (int g = 0; g < GROUPS; g++) begin
                r_energy[g] <= '0;
                r_vibr[g]   <= '0;
            end
        end else if (i_cmd.update) begin
            r_hvalid[midx] <= 1'b1;
            r_energy[gidx] <= sum_e[TOTAL_W] ? TOTAL_MAX : sum_e[TOTAL_W-1:0];
            r_vibr[gidx]   <= sum_v[TOTAL_W] ? TOTAL_MAX : sum_v[TOTAL_W-1:0];
        end
    end

    // Output register: valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register: payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_group  <= (r_op == OP_CLEAR) ? '0 : grp;
            r_out_upd    <= (r_op == OP_METER) && r_live;
            r_out_energy <= r_energy[gidx];
            r_out_vibr   <= r_vibr[gidx];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_group           = r_out_group;
    assign o_updated         = r_out_upd;
    assign o_group_energy    = r_out_energy;
    assign o_group_vibration = r_out_vibr;

    // The output register is loaded only when it is empty or being drained.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

    // A clear leaves no motor history behind.
    a_clear_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_hvalid == '0))
        else $error("history survived a clear");

    // Totals only grow between clears.
    for (genvar g = 0; g < GROUPS; g++) begin : g_mono
        a_energy_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            !i_cmd.clear |=> (r_energy[g] >= $past(r_energy[g])))
            else $error("group energy total decreased");
    end

endmodule

FILE: rtl/motor_energy_vibration_meter_core.sv
// ============================================================================
// Motor energy and vibration meter
// Meters motor samples into per-group energy and vibration totals.
//
//   Channel   Direction  Handshake                  Payload
//   in        to core    i_in_valid / o_in_stall    op, motor, alive,
//                                                   joint_velocity, torque
//   out       from core  o_out_valid / i_out_stall  group, updated,
//                                                   group_energy, group_vibration
//   cfg       to core    i_cfg_we                   i_cfg_index, i_cfg_wdata
//
// Between accepts a live sample makes four passes through the one shared
// 33x32 multiplier, then a sum step, an update step and the output load.
// A dead sample goes straight to the output load; a clear passes a clear step.
// Reset is synchronous and restores the configuration defaults and zero
// history and totals. A stalled output holds the finished word; the core
// may take the next word meanwhile and waits before loading its result.
// ============================================================================
module motor_energy_vibration_meter_core
    import mevm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration port.
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_wdata,
    // Input channel.
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_op,
    input  logic [MOTOR_W-1:0]       i_motor,
    input  logic                     i_alive,
    input  logic signed [DATA_W-1:0] i_joint_velocity,
    input  logic signed [DATA_W-1:0] i_torque,
    // Output channel.
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [GROUP_W-1:0]       o_group,
    output logic                     o_updated,
    output logic [TOTAL_W-1:0]       o_group_energy,
    output logic [TOTAL_W-1:0]       o_group_vibration
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    // Sequencer.
    mevm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // Arithmetic, state and output register.
    mevm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_op              (i_op),
        .i_motor           (i_motor),
        .i_alive           (i_alive),
        .i_joint_velocity  (i_joint_velocity),
        .i_torque          (i_torque),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_group           (o_group),
        .o_updated         (o_updated),
        .o_group_energy    (o_group_energy),
        .o_group_vibration (o_group_vibration),
        .i_cmd             (cmd),
        .o_sts             (sts)
    );

    assign o_in_stall = !in_ready;

endmodule
